// ===== rtl/tgtc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the transient gate with tempo cooldown.
// No dependencies; used by tgtc_div and transient_gate_with_tempo_cooldown.
package tgtc_pkg;

  localparam int Q12_W    = 13;
  localparam int STR_IN_W = 16;
  localparam int TS_W     = 32;
  localparam int COOL_W   = 16;
  localparam int BPM_W    = 12;
  localparam int DET_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [Q12_W-1:0] Q12_ONE        = 13'd4096;
  localparam logic [Q12_W-1:0] STRENGTH_FLOOR = 13'd40;   // must exceed 0.01
  localparam logic [BPM_W-1:0] TEMPO_MIN_Q4   = 12'd480;  // 30 bpm
  localparam logic [COOL_W-1:0] BASE_COOL_RST = 16'd80;

  // beat period / 6 in ms, scaled by 16 for the Q.4 tempo
  localparam int NUM_W = 18;
  localparam logic [NUM_W-1:0] PERIOD_NUM = 18'd160000;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam logic [COOL_W-1:0] MIN_COOLDOWN_DEF = 16'd40;
  localparam logic [COOL_W-1:0] MAX_COOLDOWN_DEF = 16'd150;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_AUDIO_LEVEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CONFIDENCE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_COOLDOWN_MS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADAPTIVE_ENABLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPO_BPM_Q4     = 3'd4;

  typedef struct packed {
    logic                 detected;
    logic [Q12_W-1:0]     confidence;
    logic [STR_IN_W-1:0]  strength;
    logic [DET_W-1:0]     detector_index;
    logic [TS_W-1:0]      timestamp_ms;
    logic [Q12_W-1:0]     audio_level;
  } in_word_t;

  typedef struct packed {
    logic                 fired;
    logic [Q12_W-1:0]     transient_strength;
    logic [Q12_W-1:0]     ensemble_confidence;
    logic                 agreement_count;
    logic [DET_W-1:0]     dominant_detector;
  } out_word_t;

  typedef struct packed {
    logic              done;
    logic [NUM_W-1:0]  quotient;
  } div_stat_t;

endpackage

// ===== rtl/tgtc_div.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring divider: PERIOD_NUM / divisor, one quotient bit a cycle.
// Depends on tgtc_pkg.
module tgtc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tgtc_pkg::BPM_W-1:0] divisor,
  output tgtc_pkg::div_stat_t        stat
);

  localparam logic [tgtc_pkg::DIV_CNT_W-1:0] LAST_STEP =
    tgtc_pkg::DIV_CNT_W'(tgtc_pkg::NUM_W - 1);

  logic                               busy;
  logic                               done;
  logic [tgtc_pkg::DIV_CNT_W-1:0]     cnt;
  logic [tgtc_pkg::BPM_W-1:0]         dvs;
  logic [tgtc_pkg::BPM_W-1:0]         rem;
  logic [tgtc_pkg::NUM_W-1:0]         quo;

  logic [tgtc_pkg::BPM_W:0]           trial;
  logic [tgtc_pkg::BPM_W:0]           diff;
  logic                               ge;
  logic [tgtc_pkg::BPM_W-1:0]         rem_next;

  // numerator bits shift out of quo's top while quotient bits shift in
  assign trial    = {rem, quo[tgtc_pkg::NUM_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign rem_next = ge ? diff[tgtc_pkg::BPM_W-1:0] : trial[tgtc_pkg::BPM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvs  <= divisor;
        rem  <= '0;
        quo  <= tgtc_pkg::PERIOD_NUM;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[tgtc_pkg::NUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.done     = done;
  assign stat.quotient = quo;

endmodule

// ===== rtl/transient_gate_with_tempo_cooldown.sv =====
`timescale 1ns / 1ps
// Top level: config registers, item sequencer, output register.
// Depends on tgtc_pkg and tgtc_div.
//
// One detection word in, one result word out. A word goes from accept through
// S_PREP to S_DECIDE when tempo adaptation is off or the tempo is below 30 bpm,
// and through S_DIV in between when the adaptive cooldown is in use, where the
// 18-step bit-serial divider forms 160000 / tempo. in_ready is high only
// while no word is in progress; a finished result sits in the output register
// and the next word may be accepted while it waits. Config writes are taken
// every cycle (cfg_ready is tied high) and must only happen while idle.
module transient_gate_with_tempo_cooldown #(
  parameter logic [tgtc_pkg::COOL_W-1:0] MIN_COOLDOWN = tgtc_pkg::MIN_COOLDOWN_DEF,
  parameter logic [tgtc_pkg::COOL_W-1:0] MAX_COOLDOWN = tgtc_pkg::MAX_COOLDOWN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tgtc_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tgtc_pkg::out_word_t             out_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tgtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tgtc_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_PREP, S_DIV, S_DECIDE} state_t;

  state_t                          state;
  logic [tgtc_pkg::Q12_W-1:0]      min_audio_level;
  logic [tgtc_pkg::Q12_W-1:0]      min_confidence;
  logic [tgtc_pkg::COOL_W-1:0]     base_cooldown_ms;
  logic                            adaptive_enable;
  logic [tgtc_pkg::BPM_W-1:0]      tempo_bpm_q4;
  logic [tgtc_pkg::TS_W-1:0]       last_transient_time;

  tgtc_pkg::in_word_t              item;
  logic                            gated;
  logic                            backward;
  logic                            str_ok;
  logic                            use_adapt;
  logic [tgtc_pkg::Q12_W-1:0]      str_q;
  logic [tgtc_pkg::TS_W-1:0]       elapsed;

  // prep-stage logic
  logic                            use_adapt_now;
  logic                            accepted_det;
  logic [tgtc_pkg::Q12_W-1:0]      str_clamp;
  logic                            div_start;
  tgtc_pkg::div_stat_t             div_stat;

  // decide-stage logic
  logic [tgtc_pkg::NUM_W-1:0]      adapt_lo;
  logic [tgtc_pkg::NUM_W-1:0]      adapt_hi;
  logic [tgtc_pkg::COOL_W-1:0]     adapt;
  logic [tgtc_pkg::COOL_W-1:0]     cooldown;
  logic                            out_free;
  logic                            fire;
  logic                            out_load;
  tgtc_pkg::out_word_t             out_next;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign use_adapt_now = adaptive_enable && (tempo_bpm_q4 >= tgtc_pkg::TEMPO_MIN_Q4);
  assign accepted_det  = item.detected && (item.confidence >= min_confidence);
  assign str_clamp = (item.strength > {3'b000, tgtc_pkg::Q12_ONE}) ? tgtc_pkg::Q12_ONE
                                                                   : item.strength[12:0];
  assign div_start = (state == S_PREP) && use_adapt_now;

  tgtc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (tempo_bpm_q4),
    .stat    (div_stat)
  );

  // raise to the floor first, then cap
  assign adapt_lo = (div_stat.quotient < {2'b00, MIN_COOLDOWN}) ? {2'b00, MIN_COOLDOWN}
                                                                : div_stat.quotient;
  assign adapt_hi = (adapt_lo > {2'b00, MAX_COOLDOWN}) ? {2'b00, MAX_COOLDOWN} : adapt_lo;
  assign adapt    = adapt_hi[tgtc_pkg::COOL_W-1:0];
  assign cooldown = (use_adapt && (adapt < base_cooldown_ms)) ? adapt : base_cooldown_ms;

  assign out_free = !out_valid || out_ready;
  assign fire     = !gated && !backward && str_ok && (elapsed > {16'd0, cooldown});
  assign out_load = (state == S_DECIDE) && out_free;

  always_comb begin
    out_next = '0;
    if (fire) begin
      out_next.fired               = 1'b1;
      out_next.transient_strength  = str_q;
      out_next.ensemble_confidence = tgtc_pkg::Q12_ONE;
      out_next.agreement_count     = 1'b1;
      out_next.dominant_detector   = item.detector_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      min_audio_level     <= '0;
      min_confidence      <= '0;
      base_cooldown_ms    <= tgtc_pkg::BASE_COOL_RST;
      adaptive_enable     <= 1'b0;
      tempo_bpm_q4        <= '0;
      last_transient_time <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          tgtc_pkg::REG_MIN_AUDIO_LEVEL:  min_audio_level  <= cfg_data[tgtc_pkg::Q12_W-1:0];
          tgtc_pkg::REG_MIN_CONFIDENCE:   min_confidence   <= cfg_data[tgtc_pkg::Q12_W-1:0];
          tgtc_pkg::REG_BASE_COOLDOWN_MS: base_cooldown_ms <= cfg_data;
          tgtc_pkg::REG_ADAPTIVE_ENABLE:  adaptive_enable  <= cfg_data[0];
          tgtc_pkg::REG_TEMPO_BPM_Q4:     tempo_bpm_q4     <= cfg_data[tgtc_pkg::BPM_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
        out_word  <= out_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_word;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          gated     <= item.audio_level < min_audio_level;
          backward  <= item.timestamp_ms < last_transient_time;
          elapsed   <= item.timestamp_ms - last_transient_time;
          str_q     <= str_clamp;
          str_ok    <= accepted_det && (str_clamp > tgtc_pkg::STRENGTH_FLOOR);
          use_adapt <= use_adapt_now;
          state     <= use_adapt_now ? S_DIV : S_DECIDE;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            if (!gated && (backward || fire)) begin
              last_transient_time <= item.timestamp_ms;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // one word in flight at a time
  a_single_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a word is in progress");

  a_fired_strength: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.fired) |->
      (out_word.transient_strength > tgtc_pkg::STRENGTH_FLOOR &&
       out_word.ensemble_confidence == tgtc_pkg::Q12_ONE && out_word.agreement_count))
    else $error("fired result with inconsistent fields");

  a_quiet_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.fired) |->
      (out_word.transient_strength == '0 && out_word.ensemble_confidence == '0 &&
       !out_word.agreement_count && out_word.dominant_detector == '0))
    else $error("non-fired result carries nonzero fields");

  a_div_only_adapt: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider finished outside the divide phase");

endmodule
